[hdl/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, widths and codes of the block table heap allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

	localparam int MAX_BLOCKS = 512;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_W     = 64;
	localparam int SIZE_W     = 32;
	localparam int BUMP_W     = 33;
	localparam int CFG_W      = 64;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_BADADDR = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CFG_HEAP_BASE  = 1'b0,
		CFG_HEAP_BYTES = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_MISS,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		logic              free;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		req_type_t         req_type;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} req_t;

	typedef struct packed {
		logic              done;
		status_t           status;
		logic [ADDR_W-1:0] block_addr;
	} result_t;

endpackage

[hdl/bta_ram.sv]
// ----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/bta_match.sv]
// ----------------------------------------------------------------------------
// bta_match
// Shared compare unit: tests one table entry against the pending request.
// ----------------------------------------------------------------------------
module bta_match (
	input  bta_pkg::entry_t ent,
	input  bta_pkg::req_t   req,
	output logic            hit
);
	import bta_pkg::*;

	always_comb begin
		if (req.req_type == REQ_ALLOC) begin
			hit = ent.free && (ent.size >= req.size);
		end else begin
			hit = (ent.addr == req.addr);
		end
	end

endmodule

[hdl/bta_seq.sv]
// ----------------------------------------------------------------------------
// bta_seq
// Request sequencer: walks the block table one entry per cycle, then reuses,
// appends, releases or reports failure.
// ----------------------------------------------------------------------------
module bta_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  bta_pkg::req_t                req_in,
	input  logic [bta_pkg::ADDR_W-1:0]   heap_base,
	input  logic [bta_pkg::SIZE_W-1:0]   heap_bytes,
	input  logic                         res_ready,
	output bta_pkg::result_t             res
);
	import bta_pkg::*;

	seq_state_t        state_q, state_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic              chk_q, chk_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [BUMP_W-1:0] bump_q, bump_d;
	req_t              req_q;
	status_t           status_q, status_d;
	logic [ADDR_W-1:0] baddr_q, baddr_d;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	entry_t            wdata;
	entry_t            rdata;
	logic              hit;
	logic [CNT_W-1:0]  hit_idx;
	logic [BUMP_W:0]   bump_end;
	logic              accept;

	bta_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	bta_match u_match (
		.ent (rdata),
		.req (req_q),
		.hit (hit)
	);

	assign accept   = in_valid && (state_q == SEQ_IDLE);
	assign in_stall = (state_q != SEQ_IDLE);
	assign hit_idx  = idx_q - CNT_W'(1);
	assign bump_end = {1'b0, bump_q} + (BUMP_W + 1)'(req_q.size);

	assign res.done       = (state_q == SEQ_DONE);
	assign res.status     = status_q;
	assign res.block_addr = baddr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			idx_q   <= '0;
			chk_q   <= 1'b0;
			count_q <= '0;
			bump_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			chk_q   <= chk_d;
			count_q <= count_d;
			bump_q  <= bump_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
		end
		status_q <= status_d;
		baddr_q  <= baddr_d;
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		chk_d    = chk_q;
		count_d  = count_q;
		bump_d   = bump_q;
		status_d = status_q;
		baddr_d  = baddr_q;
		we       = 1'b0;
		waddr    = hit_idx[IDX_W-1:0];
		wdata    = rdata;

		case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					idx_d   = '0;
					chk_d   = 1'b0;
					state_d = SEQ_SCAN;
				end
			end
			SEQ_SCAN: begin
				if (chk_q && hit) begin
					// rewrite the matched entry with its new free flag
					we         = 1'b1;
					wdata.free = (req_q.req_type == REQ_FREE);
					status_d   = ST_OK;
					baddr_d    = (req_q.req_type == REQ_ALLOC) ? rdata.addr : '0;
					state_d    = SEQ_DONE;
				end else if (idx_q < count_q) begin
					idx_d = idx_q + CNT_W'(1);
					chk_d = 1'b1;
				end else if (!chk_q) begin
					state_d = SEQ_MISS;
				end else begin
					// last entry checked without a hit: clear the check flag before the miss
					chk_d = 1'b0;
				end
			end
			SEQ_MISS: begin
				baddr_d = '0;
				state_d = SEQ_DONE;
				if (req_q.req_type == REQ_FREE) begin
					status_d = ST_BADADDR;
				end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
					status_d = ST_NOMEM;
				end else if (bump_end > (BUMP_W + 1)'(heap_bytes)) begin
					status_d = ST_NOMEM;
				end else begin
					we         = 1'b1;
					waddr      = count_q[IDX_W-1:0];
					wdata.addr = heap_base + ADDR_W'(bump_q);
					wdata.size = req_q.size;
					wdata.free = 1'b0;
					status_d   = ST_OK;
					baddr_d    = heap_base + ADDR_W'(bump_q);
					count_d    = count_q + CNT_W'(1);
					bump_d     = bump_end[BUMP_W-1:0];
				end
			end
			SEQ_DONE: begin
				if (res_ready) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

endmodule

[hdl/block_table_heap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// block_table_heap_allocator_unit
// First-fit heap allocator over a table of blocks with a bump append pointer.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     req_type, alloc_size, free_addr
//  out      out_valid / out_stall   status, block_addr
//  cfg      cfg_wen                 cfg_index, cfg_wdata
//
//  A request walks the table from entry 0, reading the table RAM one entry per
//  cycle through the single compare unit. A match ends the walk; a miss goes on
//  to a decision step (append, no memory or bad address), then to the done state.
//  The next input beat can be taken in the cycle after the result register loads.
//  After reset the table is empty and heap_bytes is 1048576; no clearing pass.
//  A result held under out_stall does not block the next input beat; that
//  request then waits for the output register before it completes.
// ----------------------------------------------------------------------------
module block_table_heap_allocator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic [bta_pkg::SIZE_W-1:0] alloc_size,
	input  logic [bta_pkg::ADDR_W-1:0] free_addr,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [bta_pkg::ADDR_W-1:0] block_addr,
	input  logic                       cfg_wen,
	input  logic                       cfg_index,
	input  logic [bta_pkg::CFG_W-1:0]  cfg_wdata
);
	import bta_pkg::*;

	logic [ADDR_W-1:0] heap_base_q;
	logic [SIZE_W-1:0] heap_bytes_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] block_addr_q;
	req_t              req;
	result_t           res;
	logic              res_ready;

	assign req.req_type = req_type_t'(req_type);
	assign req.size     = alloc_size;
	assign req.addr     = free_addr;

	assign res_ready  = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign block_addr = block_addr_q;

	bta_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_in     (req),
		.heap_base  (heap_base_q),
		.heap_bytes (heap_bytes_q),
		.res_ready  (res_ready),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_bytes_q <= SIZE_W'(1048576);
		end else if (cfg_wen) begin
			case (cfg_index_t'(cfg_index))
				CFG_HEAP_BASE:  heap_base_q  <= cfg_wdata;
				CFG_HEAP_BYTES: heap_bytes_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the output beat only when the register is free
	always_ff @(posedge clk) begin
		if (res.done && res_ready) begin
			status_q     <= res.status;
			block_addr_q <= res.block_addr;
		end
	end

endmodule
